// ===== rtl/core/firmware_section_checker_core_assert.svh =====
// Assertion macros for the firmware section checker.
`ifndef FIRMWARE_SECTION_CHECKER_CORE_ASSERT_SVH
`define FIRMWARE_SECTION_CHECKER_CORE_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define FSC_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define FSC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== rtl/core/fsc_pkg.sv =====
// ----------------------------------------------------------------------------
// fsc_pkg
// Types and constants shared by the firmware section checker.
// ----------------------------------------------------------------------------
package fsc_pkg;

  typedef enum logic [2:0] {
    PH_SEARCH, PH_TYPE, PH_VERSION, PH_LENGTH, PH_HASH, PH_START, PH_PAYLOAD
  } phase_t;

  localparam logic [31:0] CRC_POLY      = 32'h04C1_1DB7;
  localparam logic [31:0] CRC_INIT      = 32'hFFFF_FFFF;
  localparam logic [31:0] MAX_LEN_RST   = 32'h2000_0000;
  localparam logic [31:0] START_PAT_RST = 32'hBF00_0000;
  localparam logic [31:0] TAG_TOP_FW    = 32'h504D_4300;
  localparam logic [31:0] TAG_TOP_EXT   = 32'h504D_435F;
  localparam logic [63:0] TAG_FW        = 64'h504D_4300_0000_0000;
  localparam logic [63:0] TAG_BOOT      = 64'h504D_435F_424F_4F54;
  localparam logic [63:0] TAG_INIT      = 64'h504D_435F_4953_5452;
  localparam logic [31:0] TYPE_FW       = 32'h010B_0500;
  localparam logic [31:0] TYPE_BOOT     = 32'h010B_FF00;
  localparam logic [31:0] TYPE_INIT     = 32'h010B_0200;

  localparam logic [1:0] KIND_FW      = 2'd0;
  localparam logic [1:0] KIND_BOOT    = 2'd1;
  localparam logic [1:0] KIND_INIT    = 2'd2;
  localparam logic [1:0] KIND_UNKNOWN = 2'd3;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_HDR_TRUNC = 3'd1;
  localparam logic [2:0] ERR_PAY_TRUNC = 3'd2;
  localparam logic [2:0] ERR_TOO_LONG  = 3'd3;
  localparam logic [2:0] ERR_EXTRA     = 3'd4;

  localparam logic CFG_MAX_LEN   = 1'b0;
  localparam logic CFG_START_PAT = 1'b1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    logic        report_kind;
    logic [1:0]  section_kind;
    logic [2:0]  error_code;
    logic        stray_before;
    logic        type_mismatch;
    logic        version_mismatch;
    logic        start_mismatch;
    logic [31:0] kept_version;
    logic [31:0] payload_length;
    logic [31:0] declared_hash;
    logic [31:0] computed_hash;
    logic        last_of_run;
  } out_item_t;

  // Byte-wide MSB-first CRC-32 update.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      if (b[i] ^ c[31]) c = {c[30:0], 1'b0} ^ CRC_POLY;
      else c = {c[30:0], 1'b0};
    end
    return c;
  endfunction

endpackage

// ===== rtl/core/firmware_section_checker_core.sv =====
// ----------------------------------------------------------------------------
// firmware_section_checker_core
// Byte-serial scanner that finds firmware sections, checks headers and
// recomputes the payload CRC-32.
// ----------------------------------------------------------------------------
// One byte is accepted per cycle; its state update and CRC step are done in
// the same cycle. A byte yields up to two reports (section report, then end
// report), held in a two-entry output queue; input is taken whenever the
// queue has room for two, so the rate is one byte per cycle while results are
// taken and no byte has left two reports queued. After a too-long section the
// block halts and swallows bytes until reset.
module firmware_section_checker_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  fsc_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output fsc_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [31:0]        cfg_data
);
  import fsc_pkg::*;

  logic [31:0] max_len_r, start_pat_r;
  phase_t      phase_r, phase_nxt;
  logic [63:0] win_r, win_nxt;
  logic [3:0]  fill_r, fill_nxt;
  logic [1:0]  fcnt_r, fcnt_nxt;
  logic [31:0] fshift_r, fshift_nxt;
  logic [31:0] fver_r, fver_nxt;
  logic [31:0] len_r, len_nxt;
  logic [31:0] hash_r, hash_nxt;
  logic [31:0] pcnt_r, pcnt_nxt;
  logic [31:0] crc_r, crc_nxt;
  logic [3:0]  flags_r, flags_nxt;
  logic [1:0]  kind_r, kind_nxt;
  logic        halt_r, halt_nxt;

  // Output queue, two entries.
  out_item_t   q_r [2];
  logic [1:0]  qcnt_r;
  out_item_t   r0, r1;
  logic        e0, e1;

  logic acc, pop;
  assign cfg_ready = 1'b1;
  assign in_ready  = (qcnt_r == 2'd0) || (qcnt_r == 2'd1 && out_ready) ||
                     (qcnt_r == 2'd2 && out_ready && 1'b0);
  assign acc       = in_valid && in_ready;
  assign out_valid = qcnt_r != 2'd0;
  assign out_data  = q_r[0];
  assign pop       = out_valid && out_ready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r   <= MAX_LEN_RST;
      start_pat_r <= START_PAT_RST;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_MAX_LEN) max_len_r <= cfg_data;
      else start_pat_r <= cfg_data;
    end
  end

  // Per-byte next state and reports.
  always_comb begin
    logic [31:0] w;
    logic [31:0] expw;
    out_item_t   rep;
    w = '0;
    expw = '0;
    phase_nxt = phase_r; win_nxt = win_r; fill_nxt = fill_r; fcnt_nxt = fcnt_r;
    fshift_nxt = fshift_r; fver_nxt = fver_r; len_nxt = len_r; hash_nxt = hash_r;
    pcnt_nxt = pcnt_r; crc_nxt = crc_r; flags_nxt = flags_r; kind_nxt = kind_r;
    halt_nxt = halt_r;
    r0 = '0; r1 = '0; e0 = 1'b0; e1 = 1'b0;
    rep = '0;
    if (!halt_r) begin
      case (phase_r)
        PH_SEARCH: begin
          win_nxt  = {win_r[55:0], in_data.data_byte};
          fill_nxt = (fill_r == 4'd8) ? 4'd8 : fill_r + 4'd1;
          if (fill_r >= 4'd7) begin
            if (win_nxt[63:32] == TAG_TOP_FW || win_nxt[63:32] == TAG_TOP_EXT) begin
              if (win_nxt == TAG_FW) kind_nxt = KIND_FW;
              else if (win_nxt == TAG_BOOT) kind_nxt = KIND_BOOT;
              else if (win_nxt == TAG_INIT) kind_nxt = KIND_INIT;
              else kind_nxt = KIND_UNKNOWN;
              flags_nxt  = {3'b000, flags_r[0]};
              phase_nxt  = PH_TYPE;
              fcnt_nxt   = '0;
              fshift_nxt = '0;
            end else begin
              win_nxt[63:56] = 8'h00;
              fill_nxt  = 4'd7;
              flags_nxt = flags_r | 4'b0001;
            end
          end
        end
        PH_PAYLOAD: begin
          crc_nxt  = crc_byte(crc_r, in_data.data_byte);
          pcnt_nxt = pcnt_r + 32'd1;
          if (pcnt_nxt == len_r) begin
            e0 = 1'b1;
            r0 = '{report_kind: 1'b0, section_kind: kind_r, error_code: ERR_NONE,
                   stray_before: flags_r[0], type_mismatch: flags_r[1],
                   version_mismatch: flags_r[2], start_mismatch: flags_r[3],
                   kept_version: fver_r, payload_length: len_r,
                   declared_hash: hash_r, computed_hash: ~crc_nxt,
                   last_of_run: 1'b0};
            phase_nxt = PH_SEARCH; win_nxt = '0; fill_nxt = '0; fcnt_nxt = '0;
            fshift_nxt = '0; len_nxt = '0; hash_nxt = '0; pcnt_nxt = '0;
            crc_nxt = CRC_INIT; flags_nxt = '0; kind_nxt = '0;
          end
        end
        default: begin
          fshift_nxt = {fshift_r[23:0], in_data.data_byte};
          fcnt_nxt   = fcnt_r + 2'd1;
          if (fcnt_r == 2'd3) begin
            w = fshift_nxt;
            fshift_nxt = '0;
            case (phase_r)
              PH_TYPE: begin
                case (kind_r)
                  KIND_FW:   expw = TYPE_FW;
                  KIND_BOOT: expw = TYPE_BOOT;
                  default:   expw = TYPE_INIT;
                endcase
                if (kind_r != KIND_UNKNOWN && w != expw) flags_nxt[1] = 1'b1;
                phase_nxt = PH_VERSION;
              end
              PH_VERSION: begin
                if (fver_r == '0) fver_nxt = w;
                else if (fver_r != w) flags_nxt[2] = 1'b1;
                phase_nxt = PH_LENGTH;
              end
              PH_LENGTH: begin
                len_nxt = w;
                if (w > max_len_r) begin
                  e0 = 1'b1;
                  halt_nxt = 1'b1;
                  r0 = '{report_kind: 1'b0, section_kind: kind_r,
                         error_code: ERR_TOO_LONG, stray_before: flags_r[0],
                         type_mismatch: flags_r[1], version_mismatch: flags_r[2],
                         start_mismatch: flags_r[3], kept_version: fver_r,
                         payload_length: w, declared_hash: hash_r,
                         computed_hash: ~crc_r, last_of_run: 1'b1};
                end
                phase_nxt = PH_HASH;
              end
              PH_HASH: begin
                hash_nxt  = w;
                phase_nxt = PH_START;
              end
              default: begin
                if (w != start_pat_r) flags_nxt[3] = 1'b1;
                crc_nxt  = CRC_INIT;
                pcnt_nxt = '0;
                if (len_r == '0) begin
                  e0 = 1'b1;
                  r0 = '{report_kind: 1'b0, section_kind: kind_r, error_code: ERR_NONE,
                         stray_before: flags_nxt[0], type_mismatch: flags_nxt[1],
                         version_mismatch: flags_nxt[2], start_mismatch: flags_nxt[3],
                         kept_version: fver_r, payload_length: len_r,
                         declared_hash: hash_r, computed_hash: 32'h0,
                         last_of_run: 1'b0};
                  phase_nxt = PH_SEARCH; win_nxt = '0; fill_nxt = '0; fcnt_nxt = '0;
                  fshift_nxt = '0; len_nxt = '0; hash_nxt = '0;
                  crc_nxt = CRC_INIT; flags_nxt = '0; kind_nxt = '0;
                end else begin
                  phase_nxt = PH_PAYLOAD;
                end
              end
            endcase
          end
        end
      endcase

      // End of input report, taken from the updated state.
      if (in_data.end_of_input && !halt_nxt) begin
        rep = '0;
        rep.report_kind = 1'b1;
        rep.last_of_run = 1'b1;
        if (phase_nxt == PH_SEARCH) begin
          rep.error_code = (fill_nxt != 4'd0) ? ERR_EXTRA : ERR_NONE;
        end else begin
          rep.error_code = (phase_nxt == PH_PAYLOAD) ? ERR_PAY_TRUNC : ERR_HDR_TRUNC;
          rep.section_kind = kind_nxt;
          rep.stray_before = flags_nxt[0];
          rep.type_mismatch = flags_nxt[1];
          rep.version_mismatch = flags_nxt[2];
          rep.start_mismatch = flags_nxt[3];
          rep.kept_version = fver_nxt;
          rep.payload_length = len_nxt;
          rep.declared_hash = hash_nxt;
          rep.computed_hash = ~crc_nxt;
        end
        if (e0) begin
          e1 = 1'b1; r1 = rep;
        end else begin
          e0 = 1'b1; r0 = rep;
        end
        phase_nxt = PH_SEARCH; win_nxt = '0; fill_nxt = '0; fcnt_nxt = '0;
        fshift_nxt = '0; fver_nxt = '0; len_nxt = '0; hash_nxt = '0; pcnt_nxt = '0;
        crc_nxt = CRC_INIT; flags_nxt = '0; kind_nxt = '0;
      end else if (e0) begin
        r0.last_of_run = 1'b1;
      end
    end
  end

  // Stream state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SEARCH; win_r <= '0; fill_r <= '0; fcnt_r <= '0;
      fshift_r <= '0; fver_r <= '0; len_r <= '0; hash_r <= '0; pcnt_r <= '0;
      crc_r <= CRC_INIT; flags_r <= '0; kind_r <= '0; halt_r <= 1'b0;
    end else if (acc) begin
      phase_r <= phase_nxt; win_r <= win_nxt; fill_r <= fill_nxt; fcnt_r <= fcnt_nxt;
      fshift_r <= fshift_nxt; fver_r <= fver_nxt; len_r <= len_nxt;
      hash_r <= hash_nxt; pcnt_r <= pcnt_nxt; crc_r <= crc_nxt;
      flags_r <= flags_nxt; kind_r <= kind_nxt; halt_r <= halt_nxt;
    end
  end

  // Output queue: pop from the head, push the new reports behind what remains.
  always_ff @(posedge clk) begin
    logic [1:0] base;
    base = qcnt_r - {1'b0, pop};
    if (!rst_n) begin
      qcnt_r <= '0;
    end else begin
      if (acc && e0 && base == 2'd0) q_r[0] <= r0;
      else if (pop) q_r[0] <= q_r[1];
      if (acc && e1) q_r[1] <= r1;
      else if (acc && e0 && base == 2'd1) q_r[1] <= r0;
      qcnt_r <= base + {1'b0, acc && e0} + {1'b0, acc && e1};
    end
  end

  `include "firmware_section_checker_core_assert.svh"

  `FSC_ASSERT_IMPL(a_qcnt_max, 1'b1, qcnt_r <= 2'd2)
  `FSC_ASSERT_NEXT(a_halt_sticky, halt_r, halt_r)
  `FSC_ASSERT_IMPL(a_pair_order, acc && e1, e0 && r1.report_kind && !r0.report_kind)
endmodule

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the firmware section checker core. A short table
// of byte transfers is followed by generated package streams: well-formed
// sections with random content, stray bytes, wrong header words, and early
// end of input. Every result transfer is compared against a cycle-free
// predictor of the section scanner, over several register settings. The run
// ends with an over-length section that halts the block.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import fsc_pkg::*;

  localparam int IDLE_LIMIT = 3000;
  localparam int HOLD_CYCLES = 300;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = CFG_MAX_LEN;
  logic [31:0] cfg_data = '0;

  firmware_section_checker_core u_top (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready,
    .out_data, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  always #2 clk = ~clk;

  // Predicted scanner state and register copies.
  phase_t      scan_phase;
  logic [63:0] tag_win;
  logic [3:0]  win_fill;
  logic [1:0]  fld_cnt;
  logic [31:0] fld_shift;
  logic [31:0] first_ver;
  logic [31:0] sec_len;
  logic [31:0] hdr_hash;
  logic [31:0] pay_cnt;
  logic [31:0] crc_acc;
  logic        fl_stray, fl_type, fl_ver, fl_start;
  logic [1:0]  sec_kind;
  logic        halted;
  logic [31:0] max_len_reg = MAX_LEN_RST;
  logic [31:0] start_pat_reg = START_PAT_RST;

  out_item_t report_q[$];
  int errors = 0;
  int mismatches = 0;
  int items = 0;
  int reports_seen = 0;
  int section_reports = 0;
  bit eoi_sent = 0;
  bit hold_req = 0;
  int burst_left = 0;

  // Clears everything that belongs to one section.
  task automatic clear_section();
    scan_phase = PH_SEARCH;
    tag_win = '0;
    win_fill = '0;
    fld_cnt = '0;
    fld_shift = '0;
    sec_len = '0;
    hdr_hash = '0;
    pay_cnt = '0;
    crc_acc = CRC_INIT;
    {fl_stray, fl_type, fl_ver, fl_start} = '0;
    sec_kind = KIND_FW;
  endtask

  task automatic clear_stream();
    clear_section();
    first_ver = '0;
  endtask

  function automatic logic [31:0] crc_step(logic [31:0] crc, logic [7:0] b);
    logic [31:0] d;
    d = {b, 24'h0};
    for (int i = 0; i < 8; i++) begin
      crc = ((d ^ crc) & 32'h8000_0000) != 0 ? ((crc << 1) ^ CRC_POLY) : (crc << 1);
      d = d << 1;
    end
    return crc;
  endfunction

  function automatic out_item_t make_report(logic rk, logic [2:0] err, bit in_sec);
    out_item_t r;
    r = '0;
    r.report_kind = rk;
    r.error_code = err;
    if (in_sec) begin
      r.section_kind = sec_kind;
      r.stray_before = fl_stray;
      r.type_mismatch = fl_type;
      r.version_mismatch = fl_ver;
      r.start_mismatch = fl_start;
      r.kept_version = first_ver;
      r.payload_length = sec_len;
      r.declared_hash = hdr_hash;
      r.computed_hash = ~crc_acc;
    end
    return r;
  endfunction

  // Works out the reports caused by one accepted byte.
  task automatic predict_byte(in_item_t it);
    out_item_t res[$];
    logic [31:0] w;
    logic [31:0] want_type;
    if (halted) return;
    if (scan_phase == PH_SEARCH) begin
      tag_win = {tag_win[55:0], it.data_byte};
      win_fill++;
      if (win_fill >= 8) begin
        if (tag_win[63:32] == TAG_TOP_FW || tag_win[63:32] == TAG_TOP_EXT) begin
          if (tag_win == TAG_FW) sec_kind = KIND_FW;
          else if (tag_win == TAG_BOOT) sec_kind = KIND_BOOT;
          else if (tag_win == TAG_INIT) sec_kind = KIND_INIT;
          else sec_kind = KIND_UNKNOWN;
          {fl_type, fl_ver, fl_start} = '0;
          scan_phase = PH_TYPE;
          fld_cnt = '0;
          fld_shift = '0;
        end else begin
          tag_win[63:56] = 8'h00;
          win_fill = 4'd7;
          fl_stray = 1'b1;
        end
      end
    end else if (scan_phase == PH_PAYLOAD) begin
      crc_acc = crc_step(crc_acc, it.data_byte);
      pay_cnt++;
      if (pay_cnt == sec_len) begin
        res.push_back(make_report(1'b0, ERR_NONE, 1));
        clear_section();
      end
    end else begin
      fld_shift = {fld_shift[23:0], it.data_byte};
      fld_cnt = fld_cnt + 2'd1;
      if (fld_cnt == 2'd0) begin
        w = fld_shift;
        fld_shift = '0;
        case (scan_phase)
          PH_TYPE: begin
            want_type = sec_kind == KIND_FW ? TYPE_FW :
                        sec_kind == KIND_BOOT ? TYPE_BOOT : TYPE_INIT;
            if (sec_kind != KIND_UNKNOWN && w != want_type) fl_type = 1'b1;
            scan_phase = PH_VERSION;
          end
          PH_VERSION: begin
            // A zero version never becomes the kept one.
            if (first_ver == 0) first_ver = w;
            else if (first_ver != w) fl_ver = 1'b1;
            scan_phase = PH_LENGTH;
          end
          PH_LENGTH: begin
            sec_len = w;
            if (w > max_len_reg) begin
              res.push_back(make_report(1'b0, ERR_TOO_LONG, 1));
              res[0].last_of_run = 1'b1;
              report_q.push_back(res[0]);
              halted = 1'b1;
              return;
            end
            scan_phase = PH_HASH;
          end
          PH_HASH: begin
            hdr_hash = w;
            scan_phase = PH_START;
          end
          default: begin
            if (w != start_pat_reg) fl_start = 1'b1;
            crc_acc = CRC_INIT;
            pay_cnt = '0;
            if (sec_len == 0) begin
              res.push_back(make_report(1'b0, ERR_NONE, 1));
              clear_section();
            end else begin
              scan_phase = PH_PAYLOAD;
            end
          end
        endcase
      end
    end
    if (it.end_of_input) begin
      if (scan_phase == PH_SEARCH)
        res.push_back(make_report(1'b1, win_fill != 0 ? ERR_EXTRA : ERR_NONE, 0));
      else
        res.push_back(make_report(1'b1,
            scan_phase == PH_PAYLOAD ? ERR_PAY_TRUNC : ERR_HDR_TRUNC, 1));
      clear_stream();
    end
    if (res.size() > 0) res[res.size()-1].last_of_run = 1'b1;
    foreach (res[i]) report_q.push_back(res[i]);
  endtask

  // Offers one byte, in bursts with random gaps, and predicts on transfer.
  task automatic push_byte(logic [7:0] b, logic eoi);
    in_item_t it;
    int gap;
    it.data_byte = b;
    it.end_of_input = eoi;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 20);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 48);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    burst_left--;
    items++;
    predict_byte(it);
    if (eoi) eoi_sent = 1;
  endtask

  // Generated byte; a rare end of input cuts the stream short.
  task automatic put(logic [7:0] b, bit end_here = 0);
    if (eoi_sent) return;
    push_byte(b, end_here || $urandom_range(0, 199) == 0);
  endtask

  task automatic put_word(logic [31:0] w, bit end_here = 0);
    for (int i = 3; i >= 0; i--) put(w[8*i +: 8], end_here && i == 0);
  endtask

  // One section, mostly well formed, with random content.
  task automatic gen_section();
    logic [63:0] tag;
    logic [31:0] lim, len, want_type;
    int k;
    bit end_here;
    eoi_sent = 0;
    if ($urandom_range(0, 9) < 3)
      repeat ($urandom_range(1, 6)) put(8'($urandom_range(0, 255)));
    k = $urandom_range(0, 4);
    case (k)
      0: begin tag = TAG_FW; want_type = TYPE_FW; end
      1: begin tag = TAG_BOOT; want_type = TYPE_BOOT; end
      2: begin tag = TAG_INIT; want_type = TYPE_INIT; end
      3: begin tag = {TAG_TOP_EXT, $urandom()}; want_type = $urandom(); end
      default: begin tag = {TAG_TOP_FW, $urandom()}; want_type = TYPE_FW; end
    endcase
    for (int i = 7; i >= 0; i--) put(tag[8*i +: 8]);
    put_word($urandom_range(0, 9) < 7 ? want_type : $urandom());
    case ($urandom_range(0, 9))
      0, 1: put_word(32'h0);
      2: put_word($urandom());
      default: put_word(32'h0001_0203);
    endcase
    lim = max_len_reg > 48 ? 48 : max_len_reg;
    len = $urandom_range(0, 9) == 0 ? lim : $urandom_range(0, lim);
    end_here = $urandom_range(0, 4) == 0;
    put_word(len);
    put_word($urandom());
    put_word($urandom_range(0, 9) < 8 ? start_pat_reg : $urandom(), end_here && len == 0);
    for (int i = 0; i < len; i++)
      put(8'($urandom_range(0, 255)), end_here && i == len - 1);
    if ($urandom_range(0, 9) == 0) put(8'($urandom_range(0, 255)), 1'b1);
  endtask

  // Waits until every expected report has arrived and the block is quiet.
  task automatic drain();
    if (burst_left >= 0) begin
      in_valid <= 1'b0;
      burst_left = 0;
    end
    wait (report_q.size() == 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_MAX_LEN) max_len_reg = val;
    else start_pat_reg = val;
  endtask

  task automatic run_phase(logic [31:0] max_len, logic [31:0] start_pat, int n_items,
                           bit hold = 0);
    int goal;
    drain();
    write_reg(CFG_MAX_LEN, max_len);
    write_reg(CFG_START_PAT, start_pat);
    // The receiver hold-off starts once bytes are about to flow.
    if (hold) hold_req = 1;
    goal = items + n_items;
    while (items < goal) begin
      if ($urandom_range(0, 9) == 0) begin
        eoi_sent = 0;
        repeat ($urandom_range(1, 12)) put(8'($urandom_range(0, 255)));
      end else begin
        gen_section();
      end
    end
  endtask

  // Directed rows; the typed rows are end reports outside any section.
  typedef struct {
    logic [7:0] b;
    logic       eoi;
    bit         typed;
    logic [2:0] err;
  } dir_row_t;

  dir_row_t dir_tab[30] = '{
    '{8'hFF, 1'b1, 1'b1, ERR_EXTRA},
    '{8'h50, 1'b0, 1'b0, ERR_NONE}, '{8'h4D, 1'b0, 1'b0, ERR_NONE},
    '{8'h43, 1'b0, 1'b0, ERR_NONE}, '{8'h00, 1'b0, 1'b0, ERR_NONE},
    '{8'h00, 1'b0, 1'b0, ERR_NONE}, '{8'h00, 1'b0, 1'b0, ERR_NONE},
    '{8'h00, 1'b0, 1'b0, ERR_NONE}, '{8'h00, 1'b0, 1'b0, ERR_NONE},
    '{8'h01, 1'b0, 1'b0, ERR_NONE}, '{8'h0B, 1'b0, 1'b0, ERR_NONE},
    '{8'h05, 1'b0, 1'b0, ERR_NONE}, '{8'h00, 1'b0, 1'b0, ERR_NONE},
    '{8'h00, 1'b0, 1'b0, ERR_NONE}, '{8'h00, 1'b0, 1'b0, ERR_NONE},
    '{8'h00, 1'b0, 1'b0, ERR_NONE}, '{8'h00, 1'b0, 1'b0, ERR_NONE},
    '{8'h00, 1'b0, 1'b0, ERR_NONE}, '{8'h00, 1'b0, 1'b0, ERR_NONE},
    '{8'h00, 1'b0, 1'b0, ERR_NONE}, '{8'h00, 1'b0, 1'b0, ERR_NONE},
    '{8'h12, 1'b0, 1'b0, ERR_NONE}, '{8'h34, 1'b0, 1'b0, ERR_NONE},
    '{8'h56, 1'b0, 1'b0, ERR_NONE}, '{8'h78, 1'b0, 1'b0, ERR_NONE},
    '{8'hBF, 1'b0, 1'b0, ERR_NONE}, '{8'h00, 1'b0, 1'b0, ERR_NONE},
    '{8'h00, 1'b0, 1'b0, ERR_NONE}, '{8'h00, 1'b1, 1'b0, ERR_NONE},
    '{8'h50, 1'b1, 1'b1, ERR_EXTRA}
  };

  // Stimulus sequence.
  initial begin
    out_item_t want;
    halted = 1'b0;
    clear_stream();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_reg(CFG_MAX_LEN, 32'hFFFF_FFFF);
    write_reg(CFG_START_PAT, START_PAT_RST);
    foreach (dir_tab[i]) begin
      push_byte(dir_tab[i].b, dir_tab[i].eoi);
      if (dir_tab[i].typed) begin
        want = '0;
        want.report_kind = 1'b1;
        want.error_code = dir_tab[i].err;
        want.last_of_run = 1'b1;
        void'(report_q.pop_back());
        report_q.push_back(want);
      end
    end
    run_phase(32'hFFFF_FFFF, START_PAT_RST, 400);
    // Long receiver stall while bytes keep coming, so the input backs up.
    run_phase(32'd40, $urandom(), 400, 1'b1);
    // Sender pauses until every report is back before the next settings.
    run_phase(32'd0, 32'h0000_0000, 300);
    run_phase(32'd24, 32'hFFFF_FFFF, 500);
    // Over-length section halts the block; later bytes give nothing.
    drain();
    write_reg(CFG_MAX_LEN, 32'd5);
    eoi_sent = 0;
    for (int i = 7; i >= 0; i--) push_byte(TAG_BOOT[8*i +: 8], 1'b0);
    for (int i = 0; i < 8; i++) push_byte(8'h00, 1'b0);
    for (int i = 0; i < 4; i++) push_byte(i == 3 ? 8'h06 : 8'h00, 1'b0);
    repeat (6) push_byte(8'($urandom_range(0, 255)), 1'b0);
    push_byte(8'hFF, 1'b1);
    in_valid <= 1'b0;
    wait (report_q.size() == 0);
    repeat (20) @(posedge clk);
    if (report_q.size() != 0) errors++;
    $display("Sent %0d bytes; %0d reports checked, %0d of them section reports.",
             items, reports_seen, section_reports);
    $display("Covered four register settings, truncation, stray bytes and the halt.");
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Receiver: changing stall patterns, plus one long hold-off.
  initial begin
    int mode;
    mode = 0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 0;
      end
      if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 2);
      case (mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        default: out_ready <= $urandom_range(0, 3) == 0;
      endcase
    end
  end

  // Result check against the oldest expected report.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      reports_seen++;
      if (report_q.size() == 0) begin
        errors++;
        if (mismatches++ < 10) $display("Unexpected report transfer: %p", out_data);
      end else begin
        want = report_q.pop_front();
        if (!want.report_kind) section_reports++;
        if (out_data !== want) begin
          errors++;
          if (mismatches++ < 10)
            $display("Report mismatch: rk %0d/%0d kind %0d/%0d err %0d/%0d flags %b/%b ver %h/%h len %h/%h hash %h/%h crc %h/%h last %0d/%0d",
                     out_data.report_kind, want.report_kind, out_data.section_kind,
                     want.section_kind, out_data.error_code, want.error_code,
                     {out_data.stray_before, out_data.type_mismatch,
                      out_data.version_mismatch, out_data.start_mismatch},
                     {want.stray_before, want.type_mismatch, want.version_mismatch,
                      want.start_mismatch}, out_data.kept_version, want.kept_version,
                     out_data.payload_length, want.payload_length, out_data.declared_hash,
                     want.declared_hash, out_data.computed_hash, want.computed_hash,
                     out_data.last_of_run, want.last_of_run);
        end
      end
    end
  end

  // Watchdog on cycles without any transfer.
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Watchdog expired with %0d reports outstanding.", report_q.size());
      $display("tb: failure");
      $finish;
    end
  end

endmodule

// ===== firmware_section_checker_core.f =====
+incdir+rtl/core
rtl/core/fsc_pkg.sv
rtl/core/firmware_section_checker_core.sv
verif/tb_top.sv
